// ===== rtl/pps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants for the preemptive priority scheduler
// Request and response payloads, operation codes and default sizes.
// ----------------------------------------------------------------------------
package pps_pkg;

  // Default sizes for the top-level parameters
  localparam int unsigned SLOT_COUNT_DEF    = 16;
  localparam int unsigned PRIORITY_BITS_DEF = 4;
  localparam int unsigned BURST_BITS_DEF    = 8;

  // Fixed payload field widths
  localparam int unsigned OP_W          = 2;
  localparam int unsigned SLOT_FIELD_W  = 4;
  localparam int unsigned TIME_W        = 16;
  localparam int unsigned PRI_FIELD_W   = 4;
  localparam int unsigned BURST_FIELD_W = 8;
  localparam int unsigned PROG_FIELD_W  = 8;

  // Operation codes; the fourth code is ignored
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [SLOT_FIELD_W-1:0]  slot_index;
    logic [TIME_W-1:0]        entry_arrival;
    logic [PRI_FIELD_W-1:0]   entry_priority;
    logic [BURST_FIELD_W-1:0] entry_burst;
  } pps_req_t;

  typedef struct packed {
    logic [SLOT_FIELD_W-1:0] served_slot;
    logic                    idle;
    logic [PROG_FIELD_W-1:0] progress;
    logic                    task_finished;
    logic                    all_finished;
    logic [TIME_W-1:0]       tick_time;
  } pps_rsp_t;

endpackage : pps_pkg
`default_nettype wire

// ===== rtl/pps_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pps_cell: one task slot of the scheduler chain
// Holds one slot's task state, folds itself into the candidate record
// coming from its left neighbor and registers the result to the right.
// ----------------------------------------------------------------------------
module pps_cell import pps_pkg::*; #(
  parameter int unsigned CELL_INDEX    = 0,
  parameter int unsigned SLOT_COUNT    = SLOT_COUNT_DEF,
  parameter int unsigned PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int unsigned BURST_BITS    = BURST_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic [
    1 + 1 + 1 + SLOT_FIELD_W + TIME_W + PRIORITY_BITS + BURST_BITS
    + 2 * $clog2(SLOT_COUNT) + TIME_W - 1:0] cmd_i,
  input  wire logic [
    1 + $clog2(SLOT_COUNT) + PRIORITY_BITS + TIME_W + 2 * BURST_BITS
    + 1 + PRIORITY_BITS + 2 * BURST_BITS + 2 - 1:0] link_i,
  output logic [
    1 + $clog2(SLOT_COUNT) + PRIORITY_BITS + TIME_W + 2 * BURST_BITS
    + 1 + PRIORITY_BITS + 2 * BURST_BITS + 2 - 1:0] link_o
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam logic [BURST_BITS-1:0] BURST_MAX = '1;
  localparam logic [1:0] OPEN_MANY = 2'd2;

  // Same layout as the chain types in the top level
  typedef struct packed {
    logic                     load;
    logic                     restart;
    logic                     serve;
    logic [SLOT_FIELD_W-1:0]  load_slot;
    logic [TIME_W-1:0]        load_arr;
    logic [PRIORITY_BITS-1:0] load_pri;
    logic [BURST_BITS-1:0]    load_burst;
    logic [IDX_W-1:0]         serve_slot;
    logic [IDX_W-1:0]         held_slot;
    logic [TIME_W-1:0]        now;
  } cmd_t;

  typedef struct packed {
    logic                     valid;
    logic [IDX_W-1:0]         slot;
    logic [PRIORITY_BITS-1:0] pri;
    logic [TIME_W-1:0]        arr;
    logic [BURST_BITS-1:0]    prog;
    logic [BURST_BITS-1:0]    burst;
  } cand_t;

  typedef struct packed {
    logic                     ready;
    logic [PRIORITY_BITS-1:0] pri;
    logic [BURST_BITS-1:0]    prog;
    logic [BURST_BITS-1:0]    burst;
  } held_t;

  typedef struct packed {
    cand_t      cand;
    held_t      held;
    logic [1:0] open_cnt;
  } link_t;

  cmd_t  cmd;
  link_t link_in;
  link_t link_d, link_q;

  logic [TIME_W-1:0]        arr_q;
  logic [PRIORITY_BITS-1:0] pri_q;
  logic [BURST_BITS-1:0]    burst_q;
  logic [BURST_BITS-1:0]    prog_q;
  logic                     fin_q;

  logic                  ready;
  logic                  open;
  logic                  better;
  logic                  load_hit;
  logic                  serve_hit;
  logic [BURST_BITS-1:0] prog_inc;

  assign cmd     = cmd_i;
  assign link_in = link_i;
  assign link_o  = link_q;

  assign open  = (burst_q != '0) && !fin_q;
  assign ready = open && (arr_q <= cmd.now);

  // strictly better only, so the lower slot keeps a full tie
  assign better = ready && (!link_in.cand.valid || (pri_q < link_in.cand.pri) ||
                  ((pri_q == link_in.cand.pri) && (arr_q < link_in.cand.arr)));

  assign load_hit  = cmd.load && (32'(cmd.load_slot) == 32'(CELL_INDEX));
  assign serve_hit = cmd.serve && (cmd.serve_slot == IDX_W'(CELL_INDEX));
  assign prog_inc  = (prog_q == BURST_MAX) ? prog_q : prog_q + 1'b1;

  always_comb begin
    link_d = link_in;
    if (better) begin
      link_d.cand.valid = 1'b1;
      link_d.cand.slot  = IDX_W'(CELL_INDEX);
      link_d.cand.pri   = pri_q;
      link_d.cand.arr   = arr_q;
      link_d.cand.prog  = prog_q;
      link_d.cand.burst = burst_q;
    end
    if (cmd.held_slot == IDX_W'(CELL_INDEX)) begin
      link_d.held.ready = ready;
      link_d.held.pri   = pri_q;
      link_d.held.prog  = prog_q;
      link_d.held.burst = burst_q;
    end
    if (open && (link_in.open_cnt != OPEN_MANY)) begin
      link_d.open_cnt = link_in.open_cnt + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q  <= '0;
      arr_q   <= '0;
      pri_q   <= '0;
      burst_q <= '0;
      prog_q  <= '0;
      fin_q   <= 1'b0;
    end else begin
      link_q <= link_d;
      if (cmd.restart) begin
        prog_q <= '0;
        fin_q  <= 1'b0;
      end else if (load_hit) begin
        arr_q   <= cmd.load_arr;
        pri_q   <= cmd.load_pri;
        burst_q <= cmd.load_burst;
        prog_q  <= '0;
        fin_q   <= 1'b0;
      end else if (serve_hit) begin
        prog_q <= prog_inc;
        fin_q  <= (prog_inc >= burst_q);
      end
    end
  end

endmodule : pps_cell
`default_nettype wire

// ===== rtl/preemptive_priority_scheduler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler: task table with preemptive priority pick
// Loads task slots, restarts a run, and serves one task per tick.
// ----------------------------------------------------------------------------
// Each request is a load (write one slot: arrival, priority, burst; clears
// its progress), a restart (clear all progress, finish flags, time and the
// held task; the table stays) or a tick. A tick serves the held task unless
// a ready unfinished task of strictly lower priority value exists; with no
// task held it picks the lowest priority value, then earliest arrival, then
// lowest slot. The served task gains one unit and finishes at its burst. A
// tick returns one response; the other requests return none, and the fourth
// operation code is dropped. Loads to a slot at or above SLOT_COUNT are
// dropped. A tick walks a candidate record down the row of SLOT_COUNT slot
// cells, one cell per cycle, then commits; no new request is taken until
// the commit. The commit waits while the previous response still sits unread
// in the output register. Requests are taken while a response waits.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler import pps_pkg::*; #(
  parameter int unsigned SLOT_COUNT    = SLOT_COUNT_DEF,
  parameter int unsigned PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int unsigned BURST_BITS    = BURST_BITS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire pps_req_t in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output pps_rsp_t      out_rsp_o
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);
  localparam logic [PRIORITY_BITS-1:0] NONE_HELD = '1;
  localparam logic [BURST_BITS-1:0]    BURST_MAX = '1;
  localparam logic [TIME_W-1:0]        TIME_MAX  = '1;

  // Broadcast to every cell
  typedef struct packed {
    logic                     load;
    logic                     restart;
    logic                     serve;
    logic [SLOT_FIELD_W-1:0]  load_slot;
    logic [TIME_W-1:0]        load_arr;
    logic [PRIORITY_BITS-1:0] load_pri;
    logic [BURST_BITS-1:0]    load_burst;
    logic [IDX_W-1:0]         serve_slot;
    logic [IDX_W-1:0]         held_slot;
    logic [TIME_W-1:0]        now;
  } cmd_t;

  // Best ready task seen so far along the row
  typedef struct packed {
    logic                     valid;
    logic [IDX_W-1:0]         slot;
    logic [PRIORITY_BITS-1:0] pri;
    logic [TIME_W-1:0]        arr;
    logic [BURST_BITS-1:0]    prog;
    logic [BURST_BITS-1:0]    burst;
  } cand_t;

  // State of the held slot, picked up when the record passes it
  typedef struct packed {
    logic                     ready;
    logic [PRIORITY_BITS-1:0] pri;
    logic [BURST_BITS-1:0]    prog;
    logic [BURST_BITS-1:0]    burst;
  } held_t;

  typedef struct packed {
    cand_t      cand;
    held_t      held;
    logic [1:0] open_cnt;   // loaded unfinished slots, saturating at two
  } link_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e state_q;
  logic [CNT_W-1:0]         cnt_q;
  logic [TIME_W-1:0]        now_q;
  logic [IDX_W-1:0]         held_slot_q;
  logic [PRIORITY_BITS-1:0] held_pri_q;
  logic                     out_valid_q;
  pps_rsp_t                 out_q;

  cmd_t  cmd;
  link_t chain [SLOT_COUNT+1];
  link_t tail;

  logic in_acc;
  logic scan_done;
  logic commit;
  logic held_ok;
  logic pick_valid;
  logic [IDX_W-1:0]         pick_slot;
  logic [PRIORITY_BITS-1:0] pick_pri;
  logic [BURST_BITS-1:0]    pick_prog;
  logic [BURST_BITS-1:0]    pick_burst;
  logic [BURST_BITS-1:0]    new_prog;
  logic                     done;
  logic                     all_fin;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Tail of the row is complete once the record has crossed every cell
  assign scan_done = (state_q == ST_SCAN) && (cnt_q == CNT_W'(SLOT_COUNT));
  assign commit    = scan_done && (!out_valid_q || out_ready_i);

  // --------------------------------------------------------------------------
  // Cell row
  // --------------------------------------------------------------------------
  always_comb begin
    cmd            = '0;
    cmd.load       = in_acc && (in_req_i.operation == OP_LOAD) &&
                     (32'(in_req_i.slot_index) < 32'(SLOT_COUNT));
    cmd.restart    = in_acc && (in_req_i.operation == OP_RESTART);
    cmd.serve      = commit && pick_valid;
    cmd.load_slot  = in_req_i.slot_index;
    cmd.load_arr   = in_req_i.entry_arrival;
    cmd.load_pri   = PRIORITY_BITS'(in_req_i.entry_priority);
    cmd.load_burst = BURST_BITS'(in_req_i.entry_burst);
    cmd.serve_slot = pick_slot;
    cmd.held_slot  = held_slot_q;
    cmd.now        = now_q;
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    pps_cell #(
      .CELL_INDEX   (g),
      .SLOT_COUNT   (SLOT_COUNT),
      .PRIORITY_BITS(PRIORITY_BITS),
      .BURST_BITS   (BURST_BITS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .cmd_i (cmd),
      .link_i(chain[g]),
      .link_o(chain[g+1])
    );
  end

  assign tail = chain[SLOT_COUNT];

  // --------------------------------------------------------------------------
  // Pick: held task stays unless a strictly more urgent one is ready.
  // The row's best is the global best, so it beats the held task exactly
  // when its priority is lower.
  // --------------------------------------------------------------------------
  assign held_ok = (held_pri_q != NONE_HELD) && tail.held.ready;

  always_comb begin
    if (held_ok && !(tail.cand.valid && (tail.cand.pri < held_pri_q))) begin
      pick_valid = 1'b1;
      pick_slot  = held_slot_q;
      pick_pri   = tail.held.pri;
      pick_prog  = tail.held.prog;
      pick_burst = tail.held.burst;
    end else begin
      pick_valid = tail.cand.valid;
      pick_slot  = tail.cand.slot;
      pick_pri   = tail.cand.pri;
      pick_prog  = tail.cand.prog;
      pick_burst = tail.cand.burst;
    end
  end

  assign new_prog = (pick_prog == BURST_MAX) ? pick_prog : pick_prog + 1'b1;
  assign done     = pick_valid && (new_prog >= pick_burst);
  // the picked slot was open, so all done only if it was the last one
  assign all_fin  = pick_valid ? (done && (tail.open_cnt == 2'd1))
                               : (tail.open_cnt == 2'd0);

  // --------------------------------------------------------------------------
  // Control and response register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      now_q       <= '0;
      held_slot_q <= '0;
      held_pri_q  <= NONE_HELD;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // a commit in the same cycle refills the register instead
      if (out_valid_q && out_ready_i && !commit) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (cmd.restart) begin
            now_q       <= '0;
            held_slot_q <= '0;
            held_pri_q  <= NONE_HELD;
          end
          if (in_acc && (in_req_i.operation == OP_TICK)) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!scan_done) begin
            cnt_q <= cnt_q + 1'b1;
          end
          if (commit) begin
            state_q                 <= ST_IDLE;
            out_valid_q             <= 1'b1;
            out_q.served_slot       <= pick_valid ? SLOT_FIELD_W'(pick_slot) : '0;
            out_q.idle              <= !pick_valid;
            out_q.progress          <= pick_valid ? PROG_FIELD_W'(new_prog) : '0;
            out_q.task_finished     <= done;
            out_q.all_finished      <= all_fin;
            out_q.tick_time         <= now_q;
            if (now_q != TIME_MAX) begin
              now_q <= now_q + 1'b1;
            end
            if (pick_valid) begin
              if (done) begin
                held_pri_q <= NONE_HELD;
              end else begin
                held_slot_q <= pick_slot;
                held_pri_q  <= pick_pri;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule : preemptive_priority_scheduler
`default_nettype wire

// ===== bench/pps_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pps_checker: scoreboard for the preemptive priority scheduler
// Watches both handshakes, keeps its own copy of the task table, predicts
// the response of every accepted tick and compares it with what comes out.
// ----------------------------------------------------------------------------
module pps_checker import pps_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  input  wire logic     req_ready_i,
  input  wire pps_req_t req_i,
  input  wire logic     rsp_valid_i,
  input  wire logic     rsp_ready_i,
  input  wire pps_rsp_t rsp_i,
  output logic [31:0]   fail_count_o,
  output logic [31:0]   ticks_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS     = SLOT_COUNT_DEF;
  localparam int PRI_W     = PRIORITY_BITS_DEF;
  localparam int UNITS_W   = BURST_BITS_DEF;
  localparam int NONE_HELD = (1 << PRI_W) - 1;
  localparam int UNITS_MAX = (1 << UNITS_W) - 1;
  localparam int TIME_TOP  = (1 << TIME_W) - 1;

  // Task table and run state
  logic [TIME_W-1:0]  task_arrival [SLOTS];
  logic [PRI_W-1:0]   task_prio    [SLOTS];
  logic [UNITS_W-1:0] task_burst   [SLOTS];
  logic [UNITS_W-1:0] task_units   [SLOTS];
  bit                 task_done    [SLOTS];
  logic [TIME_W-1:0]  sched_time;
  int                 hold_slot;
  int                 hold_prio;

  pps_rsp_t    tick_responses [$];
  int unsigned mismatches;

  function automatic bit slot_ready(int s);
    return task_burst[s] != 0 && !task_done[s] && task_arrival[s] <= sched_time;
  endfunction

  // Most urgent ready slot below prio_limit; SLOTS when there is none.
  function automatic int most_urgent(int prio_limit);
    int best;
    best = SLOTS;
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_ready(s) && int'(task_prio[s]) < prio_limit) begin
        if (best == SLOTS || task_prio[s] < task_prio[best] ||
            (task_prio[s] == task_prio[best] &&
             task_arrival[s] < task_arrival[best])) begin
          best = s;
        end
      end
    end
    return best;
  endfunction

  task automatic restart_run();
    for (int s = 0; s < SLOTS; s++) begin
      task_units[s] = '0;
      task_done[s]  = 1'b0;
    end
    sched_time = '0;
    hold_slot  = 0;
    hold_prio  = NONE_HELD;
  endtask

  task automatic serve_tick(output pps_rsp_t r);
    int  pick;
    bit  every_done;
    pick = SLOTS;
    if (hold_prio != NONE_HELD && hold_slot < SLOTS && slot_ready(hold_slot)) begin
      pick = most_urgent(hold_prio);
      if (pick == SLOTS) pick = hold_slot;
    end else begin
      pick = most_urgent(NONE_HELD + 1);
    end

    r = '0;
    r.idle = 1'b1;
    if (pick < SLOTS) begin
      if (task_units[pick] < UNITS_MAX) task_units[pick] = task_units[pick] + 1'b1;
      if (task_units[pick] >= task_burst[pick]) begin
        task_done[pick] = 1'b1;
        hold_prio       = NONE_HELD;
        r.task_finished = 1'b1;
      end else begin
        hold_slot = pick;
        hold_prio = int'(task_prio[pick]);
      end
      r.served_slot = SLOT_FIELD_W'(pick);
      r.idle        = 1'b0;
      r.progress    = PROG_FIELD_W'(task_units[pick]);
    end

    every_done = 1'b1;
    for (int s = 0; s < SLOTS; s++) begin
      if (task_burst[s] != 0 && !task_done[s]) every_done = 1'b0;
    end
    r.all_finished = every_done;
    r.tick_time    = sched_time;
    if (sched_time < TIME_TOP) sched_time = sched_time + 1'b1;
  endtask

  task automatic apply_request(input pps_req_t q);
    pps_rsp_t r;
    case (q.operation)
      OP_LOAD: begin
        if (q.slot_index < SLOTS) begin
          task_arrival[q.slot_index] = q.entry_arrival;
          task_prio[q.slot_index]    = q.entry_priority;
          task_burst[q.slot_index]   = q.entry_burst;
          task_units[q.slot_index]   = '0;
          task_done[q.slot_index]    = 1'b0;
        end
      end
      OP_TICK: begin
        serve_tick(r);
        tick_responses = {tick_responses, r};
      end
      OP_RESTART: restart_run();
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pps_rsp_t want;
    if (!rst_ni) begin
      for (int s = 0; s < SLOTS; s++) begin
        task_arrival[s] = '0;
        task_prio[s]    = '0;
        task_burst[s]   = '0;
      end
      restart_run();
      tick_responses.delete();
      mismatches = 0;
    end else begin
      // response first: it can only belong to a tick taken earlier
      if (rsp_valid_i && rsp_ready_i) begin
        if (tick_responses.size() == 0) begin
          mismatches++;
          $display({"%0t ERROR unexpected response: ",
                    "slot=%0d idle=%0b prog=%0d fin=%0b all=%0b t=%0d"},
                   $realtime, rsp_i.served_slot, rsp_i.idle, rsp_i.progress,
                   rsp_i.task_finished, rsp_i.all_finished, rsp_i.tick_time);
        end else begin
          want = tick_responses.pop_front();
          if (rsp_i !== want) begin
            mismatches++;
            $display({"%0t ERROR tick mismatch: expected ",
                      "slot=%0d idle=%0b prog=%0d fin=%0b all=%0b t=%0d"},
                     $realtime, want.served_slot, want.idle, want.progress,
                     want.task_finished, want.all_finished, want.tick_time);
            $display({"%0t       actual          ",
                      "slot=%0d idle=%0b prog=%0d fin=%0b all=%0b t=%0d"},
                     $realtime, rsp_i.served_slot, rsp_i.idle, rsp_i.progress,
                     rsp_i.task_finished, rsp_i.all_finished, rsp_i.tick_time);
          end
        end
      end
      if (req_valid_i && req_ready_i) apply_request(req_i);
    end
    fail_count_o = mismatches;
    ticks_owed_o = tick_responses.size();
  end

endmodule : pps_checker
`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the preemptive priority scheduler
// Drives loads, ticks and restarts with random gaps and back pressure; the
// pps_checker instance predicts and compares every tick response.
// ----------------------------------------------------------------------------
module tb_top import pps_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REQUEST_BUDGET  = 600;
  localparam int MAX_GAP         = 11;
  localparam int HOLD_OFF_CYCLES = 400;   // long sink stall to back the block up
  localparam int HOLD_OFF_AT     = 60;    // responses taken before the long stall
  localparam int DRAIN_CYCLES    = 40;    // longer than one tick walk down the row
  localparam int CYCLE_LIMIT     = 400000;

  // fourth operation code: the block drops it
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  pps_req_t in_req    = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  pps_rsp_t out_rsp;

  logic [31:0] fail_count;
  logic [31:0] ticks_owed;

  int unsigned requests_sent = 0;
  int unsigned cycle_count   = 0;
  bit          back_to_back  = 1'b0;   // sender runs without gaps

  always #5 clk_i = ~clk_i;

  preemptive_priority_scheduler uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  pps_checker watch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (in_valid),
    .req_ready_i  (in_ready),
    .req_i        (in_req),
    .rsp_valid_i  (out_valid),
    .rsp_ready_i  (out_ready),
    .rsp_i        (out_rsp),
    .fail_count_o (fail_count),
    .ticks_owed_o (ticks_owed)
  );

  // Every field random, any operation code
  function automatic pps_req_t random_request();
    pps_req_t r;
    r.operation      = OP_W'($urandom_range(0, 3));
    r.slot_index     = SLOT_FIELD_W'($urandom_range(0, 15));
    r.entry_arrival  = TIME_W'($urandom_range(0, 65535));
    r.entry_priority = PRI_FIELD_W'($urandom_range(0, 15));
    r.entry_burst    = BURST_FIELD_W'($urandom_range(0, 255));
    return r;
  endfunction

  // Fields other than the operation are don't-care here, so leave them random
  function automatic pps_req_t make_op(logic [OP_W-1:0] op);
    pps_req_t r;
    r = random_request();
    r.operation = op;
    return r;
  endfunction

  function automatic pps_req_t make_load(int s, int arr, int pri, int bst);
    pps_req_t r;
    r.operation      = OP_LOAD;
    r.slot_index     = SLOT_FIELD_W'(s);
    r.entry_arrival  = TIME_W'(arr);
    r.entry_priority = PRI_FIELD_W'(pri);
    r.entry_burst    = BURST_FIELD_W'(bst);
    return r;
  endfunction

  // Mostly near-term arrivals and short bursts so tasks actually run and
  // finish; now and then far arrivals, long bursts or an empty slot.
  function automatic pps_req_t random_load();
    int arr;
    int bst;
    int roll;
    arr  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12);
    roll = $urandom_range(0, 15);
    if (roll == 0)      bst = 0;
    else if (roll == 1) bst = $urandom_range(0, 255);
    else                bst = $urandom_range(1, 6);
    return make_load($urandom_range(0, 15), arr, $urandom_range(0, 15), bst);
  endfunction

  // Offer one request after a random gap and hold it until accepted.
  // Called right after the previous acceptance edge.
  task automatic send_request(input pps_req_t r);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk_i); while (!in_ready);
    if (r.operation != OP_UNUSED) requests_sent++;
  endtask

  // Response sink: random stalls, calm stretches every 40 responses, and
  // one long hold-off so the output register fills and the input stalls.
  initial begin : sink
    int taken;
    int stall;
    bit steady;
    taken  = 0;
    steady = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (taken == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      taken++;
      if (taken % 40 == 0) steady = !steady;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed part ----
    send_request(make_op(OP_TICK));              // empty table: idle, all finished
    send_request(make_op(OP_UNUSED));            // dropped, no response
    send_request(make_load(0, 0, 15, 2));        // least urgent level: never held
    send_request(make_load(15, 65535, 0, 255));  // never arrives, blocks all_finished
    send_request(make_load(1, 2, 5, 3));         // equal priority and arrival: slot 1 wins
    send_request(make_load(2, 2, 5, 1));
    send_request(make_load(3, 1, 5, 2));         // earlier arrival wins the tie
    send_request(make_load(4, 3, 0, 1));         // most urgent level: served as soon as it arrives
    send_request(make_load(5, 0, 0, 0));         // empty slot, never served
    repeat (5) send_request(make_op(OP_TICK));
    send_request(make_load(1, 100, 1, 4));       // reload the held slot: scheduler free
    repeat (3) send_request(make_op(OP_TICK));
    send_request(make_op(OP_RESTART));           // table kept, run cleared
    repeat (3) send_request(make_op(OP_TICK));

    // ---- random part ----
    // Mostly well-formed runs: restart, a few loads, a train of ticks with
    // occasional reloads in between. Some runs wipe the table first; a few
    // bursts are plain noise with random operation codes.
    while (requests_sent < REQUEST_BUDGET) begin
      back_to_back = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) send_request(random_request());
      end else begin
        if ($urandom_range(0, 3) != 0) send_request(make_op(OP_RESTART));
        if ($urandom_range(0, 5) == 0) begin
          for (int s = 0; s < SLOT_COUNT_DEF; s++) begin
            send_request(make_load(s, $urandom_range(0, 65535), $urandom_range(0, 15), 0));
          end
        end
        repeat ($urandom_range(1, 5)) send_request(random_load());
        repeat ($urandom_range(4, 30)) begin
          if ($urandom_range(0, 7) == 0) send_request(random_load());
          send_request(make_op(OP_TICK));
        end
      end
    end

    @(negedge clk_i);
    in_valid <= 1'b0;

    // drain: every predicted tick response must come out, then stay quiet
    while (ticks_owed != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : tb_top
`default_nettype wire
